### rtl/smallest_prime_factor_sieve_unit_defines.svh
// Assertion macros used by the checker of the smallest prime factor sieve unit.
// Depends on nothing; the using scope must provide clock and reset.
`ifndef SMALLEST_PRIME_FACTOR_SIEVE_UNIT_DEFINES_SVH
`define SMALLEST_PRIME_FACTOR_SIEVE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SPF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/spf_sieve_pkg.sv
// Package of the smallest prime factor sieve: widths, codes, microcode types and ROM.
// Depends on nothing; used by the sieve top level and its checker.
`timescale 1ns / 1ps

package spf_sieve_pkg;

   localparam int unsigned MAX_NUMBER = 65535;
   localparam int NUM_W      = 16;
   localparam int COUNT_W    = 13;
   localparam int PROD_W     = 2 * NUM_W;
   localparam int TABLE_DEPTH = 1 << NUM_W;
   localparam int LIST_DEPTH  = 1 << COUNT_W;

   typedef logic [NUM_W-1:0]   num_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PROD_W-1:0]  prod_type;

   // Largest usable limit; the fixed field width caps it as well.
   localparam num_type LIMIT_CAP = (MAX_NUMBER > 65535) ? 16'hFFFF : NUM_W'(MAX_NUMBER);

   // Request kinds.
   localparam logic REQ_BUILD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_ABOVE_LIMIT = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT   = 2'd2;

   // Datapath actions of one microinstruction.
   typedef enum logic [3:0] {
      OP_NOP, OP_QCHECK, OP_QRESP, OP_BINIT, OP_CLEAR, OP_ISET, OP_RDI,
      OP_MARK, OP_RDP, OP_MUL, OP_WRP, OP_INCI, OP_BUILT, OP_BRESP
   } op_type;

   // Branch conditions of one microinstruction.
   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_DISPATCH, C_OUT_FREE, C_LIM_LT2, C_I_NE_LIM,
      C_J_GE_TOTAL, C_P_GT_FI, C_PROD_GT_LIM
   } cond_type;

   typedef logic [3:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_QCHECK = 4'd1;
   localparam step_type STEP_QRESP  = 4'd2;
   localparam step_type STEP_BINIT  = 4'd3;
   localparam step_type STEP_CLEAR  = 4'd4;
   localparam step_type STEP_ISET   = 4'd5;
   localparam step_type STEP_RDI    = 4'd6;
   localparam step_type STEP_MARK   = 4'd7;
   localparam step_type STEP_RDP    = 4'd8;
   localparam step_type STEP_MUL    = 4'd9;
   localparam step_type STEP_TEST   = 4'd10;
   localparam step_type STEP_WRP    = 4'd11;
   localparam step_type STEP_NEXT   = 4'd12;
   localparam step_type STEP_FIN    = 4'd13;
   localparam step_type STEP_BRESP  = 4'd14;

   // The microprogram. A true condition jumps to target, otherwise the
   // sequencer moves on; dispatch and output-free conditions hold in place.
   function automatic uword_type ucode_rom(step_type pc);
      uword_type w;
      unique case (pc)
         STEP_IDLE:   w = '{op: OP_NOP,    cond: C_DISPATCH,    target: STEP_BINIT};
         STEP_QCHECK: w = '{op: OP_QCHECK, cond: C_NEVER,       target: STEP_IDLE};
         STEP_QRESP:  w = '{op: OP_QRESP,  cond: C_OUT_FREE,    target: STEP_IDLE};
         STEP_BINIT:  w = '{op: OP_BINIT,  cond: C_LIM_LT2,     target: STEP_FIN};
         STEP_CLEAR:  w = '{op: OP_CLEAR,  cond: C_I_NE_LIM,    target: STEP_CLEAR};
         STEP_ISET:   w = '{op: OP_ISET,   cond: C_NEVER,       target: STEP_IDLE};
         STEP_RDI:    w = '{op: OP_RDI,    cond: C_NEVER,       target: STEP_IDLE};
         STEP_MARK:   w = '{op: OP_MARK,   cond: C_NEVER,       target: STEP_IDLE};
         STEP_RDP:    w = '{op: OP_RDP,    cond: C_J_GE_TOTAL,  target: STEP_NEXT};
         STEP_MUL:    w = '{op: OP_MUL,    cond: C_P_GT_FI,     target: STEP_NEXT};
         STEP_TEST:   w = '{op: OP_NOP,    cond: C_PROD_GT_LIM, target: STEP_NEXT};
         STEP_WRP:    w = '{op: OP_WRP,    cond: C_ALWAYS,      target: STEP_RDP};
         STEP_NEXT:   w = '{op: OP_INCI,   cond: C_I_NE_LIM,    target: STEP_RDI};
         STEP_FIN:    w = '{op: OP_BUILT,  cond: C_NEVER,       target: STEP_IDLE};
         STEP_BRESP:  w = '{op: OP_BRESP,  cond: C_OUT_FREE,    target: STEP_IDLE};
         default:     w = '{op: OP_NOP,    cond: C_ALWAYS,      target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/smallest_prime_factor_sieve_unit.sv
// Top level of the smallest prime factor sieve: microcoded sequencer, datapath and memories.
// Depends on spf_sieve_pkg for widths, codes and the microprogram ROM.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_type, req_query_number
//   rsp      out        rsp_valid / rsp_stall   rsp_smallest_factor, rsp_prime_flag,
//                                               rsp_primes_found, rsp_status
//   csr      in         csr_valid / csr_ready   csr_sieve_limit
//
// Query: after acceptance the table is read, then the result register is loaded.
// Build: clears entries two up to the limit, then for each number reads the table, marks
// it as prime if unmarked and strikes its multiples by the listed primes up to its factor.
// Reset is synchronous and active high; it clears the sequencer, the built flag and the
// prime count, and sets the limit to 65535. A result held by rsp_stall still lets the
// next request in, which then waits in its response step with req_stall high.
`timescale 1ns / 1ps

module smallest_prime_factor_sieve_unit import spf_sieve_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [NUM_W-1:0]  req_query_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [NUM_W-1:0]  rsp_smallest_factor,
   output logic              rsp_prime_flag,
   output logic [COUNT_W-1:0] rsp_primes_found,
   output logic [1:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NUM_W-1:0]  csr_sieve_limit
);

   // Sequencer and control state.
   step_type  pc_ff, pc_in;
   logic      built_ff, built_in;
   num_type   limit_ff, limit_in;

   // Datapath registers: i walks the numbers, j walks the prime list.
   num_type   i_ff, i_in;
   count_type j_ff, j_in;
   count_type total_ff, total_in;
   num_type   fi_ff, fi_in;
   prod_type  prod_ff, prod_in;
   num_type   num_ff, num_in;
   logic [1:0] qstat_ff, qstat_in;

   // Result register.
   logic      rsp_valid_ff, rsp_valid_in;
   num_type   rsp_factor_ff, rsp_factor_in;
   logic      rsp_flag_ff, rsp_flag_in;
   count_type rsp_primes_ff, rsp_primes_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   // Memories. The factor table needs no reset: its read data is only used after a build
   // has cleared every entry from two up to the limit.
   num_type   factor_mem [TABLE_DEPTH];
   num_type   prime_mem  [LIST_DEPTH];
   num_type   tab_rdata_ff;
   num_type   lst_rdata_ff;

   logic      tab_we, tab_re, lst_we, lst_re;
   num_type   tab_waddr, tab_wdata, tab_raddr;

   uword_type uword;
   num_type   eff_lim;
   logic      req_accept;
   logic      out_free;
   logic      prod_over;

   assign req_stall  = (pc_ff != STEP_IDLE);
   assign csr_ready  = (pc_ff == STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign eff_lim    = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign prod_over  = prod_ff > {{(PROD_W-NUM_W){1'b0}}, eff_lim};
   assign uword      = ucode_rom(pc_ff);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_smallest_factor = rsp_factor_ff;
   assign rsp_prime_flag      = rsp_flag_ff;
   assign rsp_primes_found    = rsp_primes_ff;
   assign rsp_status          = rsp_status_ff;

   // Next step: branch on the condition named by the control word.
   always_comb begin
      pc_in = step_type'(pc_ff + 4'd1);
      unique case (uword.cond)
         C_NEVER: begin
         end
         C_ALWAYS: begin
            pc_in = uword.target;
         end
         C_DISPATCH: begin
            if (!req_accept) begin
               pc_in = pc_ff;
            end else if (req_type == REQ_BUILD) begin
               pc_in = uword.target;
            end
         end
         C_OUT_FREE: begin
            pc_in = out_free ? uword.target : pc_ff;
         end
         C_LIM_LT2: begin
            if (eff_lim < num_type'(2)) pc_in = uword.target;
         end
         C_I_NE_LIM: begin
            if (i_ff != eff_lim) pc_in = uword.target;
         end
         C_J_GE_TOTAL: begin
            if (j_ff >= total_ff) pc_in = uword.target;
         end
         C_P_GT_FI: begin
            if (lst_rdata_ff > fi_ff) pc_in = uword.target;
         end
         C_PROD_GT_LIM: begin
            if (prod_over) pc_in = uword.target;
         end
         default: begin
            pc_in = STEP_IDLE;
         end
      endcase
   end

   // Datapath actions named by the control word.
   always_comb begin
      built_in      = built_ff;
      limit_in      = limit_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      total_in      = total_ff;
      fi_in         = fi_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      qstat_in      = qstat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_factor_in = rsp_factor_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_primes_in = rsp_primes_ff;
      rsp_status_in = rsp_status_ff;
      tab_we        = 1'b0;
      tab_re        = 1'b0;
      tab_waddr     = i_ff;
      tab_wdata     = '0;
      tab_raddr     = i_ff;
      lst_we        = 1'b0;
      lst_re        = 1'b0;

      if (req_accept) begin
         num_in = req_query_number;
      end

      unique case (uword.op)
         OP_NOP: begin
         end
         OP_QCHECK: begin
            // The not-built check comes before the limit check.
            if (!built_ff) begin
               qstat_in = ST_NOT_BUILT;
            end else if (num_ff > eff_lim) begin
               qstat_in = ST_ABOVE_LIMIT;
            end else begin
               qstat_in = ST_OK;
            end
            tab_re    = 1'b1;
            tab_raddr = num_ff;
         end
         OP_QRESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = qstat_ff;
               rsp_primes_in = total_ff;
               if (qstat_ff == ST_OK && num_ff >= num_type'(2)) begin
                  rsp_factor_in = tab_rdata_ff;
                  rsp_flag_in   = (tab_rdata_ff == num_ff);
               end else begin
                  rsp_factor_in = '0;
                  rsp_flag_in   = 1'b0;
               end
            end
         end
         OP_BINIT: begin
            i_in     = num_type'(2);
            total_in = '0;
         end
         OP_CLEAR: begin
            tab_we    = 1'b1;
            tab_waddr = i_ff;
            tab_wdata = '0;
            i_in      = num_type'(i_ff + num_type'(1));
         end
         OP_ISET: begin
            i_in = num_type'(2);
         end
         OP_RDI: begin
            tab_re    = 1'b1;
            tab_raddr = i_ff;
         end
         OP_MARK: begin
            // An unmarked number is prime: it is its own factor and joins the list.
            j_in = '0;
            if (tab_rdata_ff == '0) begin
               tab_we    = 1'b1;
               tab_waddr = i_ff;
               tab_wdata = i_ff;
               lst_we    = 1'b1;
               total_in  = count_type'(total_ff + count_type'(1));
               fi_in     = i_ff;
            end else begin
               fi_in = tab_rdata_ff;
            end
         end
         OP_RDP: begin
            lst_re = 1'b1;
         end
         OP_MUL: begin
            prod_in = prod_type'(lst_rdata_ff) * prod_type'(i_ff);
         end
         OP_WRP: begin
            tab_we    = 1'b1;
            tab_waddr = prod_ff[NUM_W-1:0];
            tab_wdata = lst_rdata_ff;
            j_in      = count_type'(j_ff + count_type'(1));
         end
         OP_INCI: begin
            i_in = num_type'(i_ff + num_type'(1));
         end
         OP_BUILT: begin
            built_in = 1'b1;
         end
         OP_BRESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_primes_in = total_ff;
               rsp_factor_in = '0;
               rsp_flag_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // A new limit invalidates the table.
      if (csr_valid && csr_ready) begin
         limit_in = csr_sieve_limit;
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         built_ff     <= 1'b0;
         limit_ff     <= 16'hFFFF;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         built_ff     <= built_in;
         limit_ff     <= limit_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      fi_ff         <= fi_in;
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      qstat_ff      <= qstat_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_primes_ff <= rsp_primes_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Smallest-factor table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         factor_mem[tab_waddr] <= tab_wdata;
      end
      if (tab_re) begin
         tab_rdata_ff <= factor_mem[tab_raddr];
      end
   end

   // Prime list: appended at the prime count, read at j.
   always_ff @(posedge clock) begin
      if (lst_we) begin
         prime_mem[total_ff] <= i_ff;
      end
      if (lst_re) begin
         lst_rdata_ff <= prime_mem[j_ff];
      end
   end

endmodule

### rtl/spf_sieve_checker.sv
// Port-level checker of the smallest prime factor sieve unit, bound to its top level.
// Depends on spf_sieve_pkg and smallest_prime_factor_sieve_unit_defines.svh.
`timescale 1ns / 1ps
`include "smallest_prime_factor_sieve_unit_defines.svh"

module spf_sieve_checker import spf_sieve_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_type,
   input logic [NUM_W-1:0]  req_query_number,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [NUM_W-1:0]  rsp_smallest_factor,
   input logic              rsp_prime_flag,
   input logic [COUNT_W-1:0] rsp_primes_found,
   input logic [1:0]        rsp_status,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [NUM_W-1:0]  csr_sieve_limit
);

   // A stalled result stays offered.
   `SPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

   // A stalled result keeps its payload.
   `SPF_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_smallest_factor) && $stable(rsp_prime_flag) && $stable(rsp_primes_found) && $stable(rsp_status), "stalled result changed")

   // The unit works on one request at a time.
   `SPF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request taken while busy")

   // A prime answer only comes with a good status and a real factor.
   `SPF_ASSERT_IMPLIES(a_prime_ok, rsp_valid && rsp_prime_flag, rsp_status == ST_OK && rsp_smallest_factor >= 16'd2, "prime flag with bad status or factor")

   // An error answer carries no factor and no prime flag.
   `SPF_ASSERT_IMPLIES(a_err_clean, rsp_valid && rsp_status != ST_OK, !rsp_prime_flag && rsp_smallest_factor == 16'd0, "error result with factor data")

endmodule

bind smallest_prime_factor_sieve_unit spf_sieve_checker u_spf_sieve_checker (.*);

### verif/tb_smallest_prime_factor_sieve_unit.sv
// Self-checking testbench of smallest_prime_factor_sieve_unit: directed and random requests,
// every answer compared against a linear sieve kept inside the bench.
// Depends on spf_sieve_pkg for widths, request kinds and status codes.
`timescale 1ns / 1ps

module tb_smallest_prime_factor_sieve_unit;
   import spf_sieve_pkg::*;

   // A full-limit build accepts nothing on any channel until it is done,
   // so the watchdog must sit well above the length of such a build.
   localparam int WATCHDOG_LIMIT = 2_000_000;
   // A query needs only a table read and a result load; this is ample for the tail.
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_OFF_LEN   = 300;

   // One answer of the block, as the checker expects it.
   typedef struct {
      num_type    factor;
      logic       prime;
      count_type  count;
      logic [1:0] status;
   } sieve_answer_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_type         = REQ_QUERY;
   num_type            req_query_number = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   num_type            rsp_smallest_factor;
   logic               rsp_prime_flag;
   count_type          rsp_primes_found;
   logic [1:0]         rsp_status;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   num_type            csr_sieve_limit  = '0;

   // Local copy of the block state, updated at each accepted build request or register write.
   num_type            spf_of [TABLE_DEPTH];
   int unsigned        found_primes [$];
   num_type            limit_reg;
   logic               table_ready;
   count_type          prime_count;

   sieve_answer_type   pending_answers [$];
   int                 error_count   = 0;
   int                 quiet_cycles  = 0;
   int                 send_idle_pct = 0;
   int                 stall_pct     = 0;
   int                 hold_off_left = 0;

   smallest_prime_factor_sieve_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_query_number    (req_query_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_smallest_factor (rsp_smallest_factor),
      .rsp_prime_flag      (rsp_prime_flag),
      .rsp_primes_found    (rsp_primes_found),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_sieve_limit     (csr_sieve_limit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The register is 16 bits wide, so the cap only bites if the number range shrinks.
   function automatic int unsigned usable_limit();
      return (limit_reg > MAX_NUMBER) ? MAX_NUMBER : int'(limit_reg);
   endfunction

   // Linear sieve: each composite is struck exactly once, by its smallest prime factor.
   function automatic void rebuild_spf_table();
      int unsigned     lim;
      int unsigned     p;
      longint unsigned prod;
      lim = usable_limit();
      for (int k = 0; k < TABLE_DEPTH; k++)
         spf_of[k] = '0;
      found_primes.delete();
      for (int unsigned i = 2; i <= lim; i++) begin
         if (spf_of[i] == '0) begin
            spf_of[i] = num_type'(i);
            found_primes.push_back(i);
         end
         for (int j = 0; j < found_primes.size(); j++) begin
            p = found_primes[j];
            if (p > spf_of[i])
               break;
            prod = longint'(p) * longint'(i);
            if (prod > lim)
               break;
            spf_of[prod] = num_type'(p);
         end
      end
      prime_count = count_type'(found_primes.size());
      table_ready = 1'b1;
   endfunction

   // Works out the answer to one accepted request; a build also replaces the table.
   function automatic sieve_answer_type predict_answer(logic kind, num_type number);
      sieve_answer_type a;
      a.factor = '0;
      a.prime  = 1'b0;
      a.status = ST_OK;
      if (kind == REQ_BUILD) begin
         rebuild_spf_table();
      end else if (!table_ready) begin
         // An unbuilt table wins over the limit check.
         a.status = ST_NOT_BUILT;
      end else if (number > usable_limit()) begin
         a.status = ST_ABOVE_LIMIT;
      end else if (number >= 2) begin
         // Zero and one fall through with factor 0 and no prime flag.
         a.factor = spf_of[number];
         a.prime  = (spf_of[number] == number);
      end
      a.count = prime_count;
      return a;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Each accepted request pushes its expected answer at the very edge it is taken.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_answers.push_back(predict_answer(req_type, req_query_number));
   end

   // Each accepted answer is matched field by field against the oldest expectation.
   always @(posedge clock) begin : answer_check
      sieve_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected answer, factor", rsp_smallest_factor, 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_smallest_factor !== want.factor)
               report_mismatch("smallest_factor", rsp_smallest_factor, want.factor);
            if (rsp_prime_flag !== want.prime)
               report_mismatch("prime_flag", rsp_prime_flag, want.prime);
            if (rsp_primes_found !== want.count)
               report_mismatch("primes_found", rsp_primes_found, want.count);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // The receiver either stalls at random or, during a hold-off, stalls solidly
   // for a counted stretch so the block backs up into its request side.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Ends the run if nothing moves on any channel for far longer than a full build.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_smallest_prime_factor_sieve_unit: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request, with random idle cycles ahead of it, and returns at the
   // rising edge where it is taken. Valid is not dropped when a request is taken, so
   // back-to-back requests keep it high.
   task automatic send_request(logic kind, num_type number);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_query_number <= number;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drops valid and waits at falling edges, after every monitor has run, until
   // all expected answers are in.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0)
         @(negedge clock);
   endtask

   // Writes the limit register; the block then treats its table as unbuilt.
   task automatic write_sieve_limit(num_type value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_sieve_limit <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      limit_reg   = value;
      table_ready = 1'b0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly numbers inside the table, with the limit edge and the full range mixed in.
   function automatic num_type pick_query(int unsigned lim);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 65)
         return num_type'($urandom_range(lim));
      if (roll < 75)
         return num_type'(lim);
      if (roll < 82)
         return num_type'((lim < MAX_NUMBER) ? lim + 1 : lim);
      return num_type'($urandom_range(65535));
   endfunction

   // Straight out of reset nothing is built, whatever the number.
   task automatic test_unbuilt_queries();
      send_request(REQ_QUERY, 16'd0);
      send_request(REQ_QUERY, 16'd1);
      send_request(REQ_QUERY, 16'hFFFF);
      send_request(REQ_QUERY, 16'd2);
   endtask

   // One build at the reset limit covers the whole table; queries hit its extremes,
   // including the largest 16-bit prime and numbers with large factors.
   task automatic test_full_limit_build();
      send_request(REQ_BUILD, 16'hFFFF);
      send_request(REQ_QUERY, 16'd0);
      send_request(REQ_QUERY, 16'd1);
      send_request(REQ_QUERY, 16'd2);
      send_request(REQ_QUERY, 16'd4);
      send_request(REQ_QUERY, 16'd65521);
      send_request(REQ_QUERY, 16'd65534);
      send_request(REQ_QUERY, 16'hFFFF);
      send_request(REQ_QUERY, 16'd32768);
      wait_until_idle();
   endtask

   // A limit of two, the smallest that holds a prime, and a rewrite of the largest that leaves the table unbuilt.
   task automatic test_limit_extremes();
      write_sieve_limit(16'd2);
      send_request(REQ_QUERY, 16'd2);
      send_request(REQ_BUILD, 16'd0);
      send_request(REQ_QUERY, 16'd1);
      send_request(REQ_QUERY, 16'd2);
      send_request(REQ_QUERY, 16'd3);
      send_request(REQ_QUERY, 16'hFFFF);
      wait_until_idle();
      write_sieve_limit(16'hFFFF);
      send_request(REQ_QUERY, 16'd5);
      wait_until_idle();
   endtask

   // The receiver holds off for a long stretch while queries keep coming, so the
   // block must fill and stall its input; then the sender waits for everything.
   task automatic test_back_pressure();
      int unsigned lim;
      send_idle_pct = 0;
      stall_pct     = 0;
      lim = $urandom_range(300, 1000);
      write_sieve_limit(num_type'(lim));
      send_request(REQ_BUILD, num_type'($urandom));
      wait_until_idle();
      @(posedge clock);
      hold_off_left = HOLD_OFF_LEN;
      repeat (30)
         send_request(REQ_QUERY, pick_query(lim));
      wait_until_idle();
   endtask

   // One idling setting: a fresh small limit, its build, then random requests with
   // an occasional rebuild. Sometimes a query goes in before the build.
   task automatic test_idle_phase(int send_pct, int recv_pct, int count);
      int unsigned lim;
      int unsigned roll;
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      roll = $urandom_range(99);
      if (roll < 15)
         lim = 2;
      else if (roll < 55)
         lim = $urandom_range(3, 64);
      else
         lim = $urandom_range(65, 1200);
      write_sieve_limit(num_type'(lim));
      if ($urandom_range(1) == 1)
         send_request(REQ_QUERY, pick_query(lim));
      send_request(REQ_BUILD, num_type'($urandom));
      repeat (count) begin
         if ($urandom_range(99) < 8)
            send_request(REQ_BUILD, num_type'($urandom));
         else
            send_request(REQ_QUERY, pick_query(lim));
      end
      wait_until_idle();
   endtask

   initial begin
      // Block state after reset.
      limit_reg   = 16'hFFFF;
      table_ready = 1'b0;
      prime_count = '0;
      for (int k = 0; k < TABLE_DEPTH; k++)
         spf_of[k] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_unbuilt_queries();
      test_full_limit_build();
      test_limit_extremes();
      test_back_pressure();
      test_idle_phase(0, 0, 12);
      test_idle_phase(49, 0, 12);
      test_idle_phase(0, 49, 12);
      test_idle_phase(25, 25, 12);

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch("answers never returned, count", pending_answers.size(), 0);
      if (error_count == 0)
         $display("tb_smallest_prime_factor_sieve_unit: done, clean");
      else
         $display("tb_smallest_prime_factor_sieve_unit: done, errors");
      $finish;
   end

endmodule
